[hw/rtl/ctw_pkg.sv]
package ctw_pkg;

  localparam int DefColumns = 80;
  localparam int DefRows    = 25;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  typedef enum logic [2:0] {
    OP_PUT_CHAR  = 3'd0,
    OP_BACKSPACE = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_SET_CUR   = 3'd3,
    OP_WRITE_AT  = 3'd4,
    OP_READ_CELL = 3'd5
  } ctw_op_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [7:0] column;
    logic [7:0] row;
  } ctw_req_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_attribute;
    logic [7:0]  cursor_row_now;
    logic [7:0]  cursor_col_now;
    logic [15:0] cursor_position;
    logic        position_valid;
  } ctw_rsp_t;

endpackage

[hw/rtl/ctw_stream_if.sv]
interface ctw_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/ctw_ram.sv]
module ctw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ctw_addr_unit.sv]
// Registered row * COLUMNS + column, shared by every single-cell access and the
// cursor position report; init, clear and scroll sweeps use their own counter.
module ctw_addr_unit #(
  parameter int COLUMNS = 80,
  parameter int AW      = 11
) (
  input  logic          clk_i,
  input  logic [7:0]    row_i,
  input  logic [7:0]    col_i,
  output logic [AW-1:0] addr_o
);

  logic [15:0]   lin;
  logic [AW-1:0] addr_q;

  assign lin = 16'(row_i) * 16'(COLUMNS) + 16'(col_i);

  always_ff @(posedge clk_i) begin
    addr_q <= lin[AW-1:0];
  end

  assign addr_o = addr_q;

endmodule

[hw/rtl/text_console_writer.sv]
// Channel  | Dir | Payload    | Notes
// ---------+-----+------------+-----------------------------------------
// req_i    | in  | ctw_req_t  | one request per operation
// rsp_o    | out | ctw_rsp_t  | exactly one response per request
// cfg      | in  | 8-bit data | default_attribute, write when idle
//
// After reset the store is swept to blanks, one cell a cycle, with
// req_i.ready low throughout.
// A request is taken only in the idle state. Put char, write at and set
// cursor go from a plan state through an address and an access state to the
// response, read cell also through a read wait, newline and out-of-range
// requests straight from plan to response; the extra states come from the
// shared address multiply-add and the registered read port of the store.
// Clear sweeps every cell; a scrolling put char first rewrites every cell.
// A waiting response does not block acceptance; the next one waits until
// it has been taken.
module text_console_writer
  import ctw_pkg::*;
#(
  parameter int COLUMNS = DefColumns,
  parameter int ROWS    = DefRows
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctw_stream_if.sink   req_i,
  ctw_stream_if.source rsp_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CW    = $clog2(COLUMNS + 1);

  localparam logic [RW-1:0] ROWS_L     = RW'(ROWS);
  localparam logic [CW-1:0] COLS_L     = CW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_LAST  = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] FILL_START = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);

  typedef enum logic [9:0] {
    S_INIT     = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_PLAN     = 10'b0000000100,
    S_CLEAR    = 10'b0000001000,
    S_SCR_COPY = 10'b0000010000,
    S_SCR_FILL = 10'b0000100000,
    S_ADDR     = 10'b0001000000,
    S_ACT      = 10'b0010000000,
    S_RDWAIT   = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] dst_q, dst_d;
  logic          pend_q, pend_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [7:0]    tgt_row_q, tgt_row_d;
  logic [7:0]    tgt_col_q, tgt_col_d;
  logic [15:0]   wdata_q, wdata_d;
  logic [7:0]    fill_attr_q, fill_attr_d;
  logic          do_wr_q, do_wr_d;
  logic          do_rd_q, do_rd_d;
  logic          posv_q, posv_d;
  logic [15:0]   pos_q, pos_d;
  logic [15:0]   rd_cell_q, rd_cell_d;
  logic [7:0]    def_attr_q;
  ctw_req_t      req_q;
  ctw_rsp_t      rsp_q;
  logic          rsp_valid_q, rsp_valid_d;
  logic          rsp_load;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;
  logic [AW-1:0] unit_addr;

  logic          req_fire;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // Shared multiply-add: forms the cell addresses of single-cell requests.
  ctw_addr_unit #(
    .COLUMNS(COLUMNS),
    .AW     (AW)
  ) u_addr (
    .clk_i (clk_i),
    .row_i (tgt_row_q),
    .col_i (tgt_col_q),
    .addr_o(unit_addr)
  );

  ctw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Sequencer and cursor update.
  always_comb begin
    logic          nl;
    logic          wrap;
    logic [RW-1:0] r1;
    logic [CW-1:0] c1;
    logic [RW-1:0] wrow;
    logic          in_range;

    state_d     = state_q;
    cnt_d       = cnt_q;
    dst_d       = dst_q;
    pend_d      = 1'b0;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    tgt_row_d   = tgt_row_q;
    tgt_col_d   = tgt_col_q;
    wdata_d     = wdata_q;
    fill_attr_d = fill_attr_q;
    do_wr_d     = do_wr_q;
    do_rd_d     = do_rd_q;
    posv_d      = posv_q;
    pos_d       = pos_q;
    rd_cell_d   = rd_cell_q;
    rsp_load    = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = {fill_attr_q, BLANK_CHAR};
    ram_raddr = unit_addr;

    nl       = (req_q.char_code == NEWLINE_CHAR);
    wrap     = nl || (cur_col_q >= COLS_L);
    r1       = (wrap && (cur_row_q < ROWS_L)) ? cur_row_q + RW'(1) : cur_row_q;
    c1       = wrap ? '0 : cur_col_q;
    wrow     = (r1 >= ROWS_L) ? ROWS_L - RW'(1) : r1;
    in_range = (req_q.column < 8'(COLUMNS)) && (req_q.row < 8'(ROWS));

    unique case (state_q)
      S_INIT: begin
        ram_we = 1'b1;
        if (cnt_q == LAST_CELL) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (req_fire) begin
          state_d = S_PLAN;
        end
      end

      S_PLAN: begin
        do_wr_d   = 1'b0;
        do_rd_d   = 1'b0;
        posv_d    = 1'b0;
        pos_d     = '0;
        rd_cell_d = '0;
        cnt_d     = '0;
        tgt_row_d = req_q.row;
        tgt_col_d = req_q.column;
        wdata_d   = {req_q.attribute, req_q.char_code};
        state_d   = S_DONE;
        case (req_q.opcode)
          OP_PUT_CHAR: begin
            if (nl) begin
              cur_row_d = r1;
              cur_col_d = '0;
            end else begin
              cur_row_d = wrow;
              cur_col_d = c1 + CW'(1);
              tgt_row_d = 8'(wrow);
              tgt_col_d = 8'(c1);
              do_wr_d   = 1'b1;
              if (r1 >= ROWS_L) begin
                // bottom passed: scroll first, then write on the last row
                fill_attr_d = def_attr_q;
                state_d     = (ROWS > 1) ? S_SCR_COPY : S_SCR_FILL;
              end else begin
                state_d = S_ADDR;
              end
            end
          end
          OP_BACKSPACE: begin
            wdata_d = {def_attr_q, BLANK_CHAR};
            if (cur_col_q != '0) begin
              cur_col_d = cur_col_q - CW'(1);
              tgt_row_d = 8'(cur_row_q);
              tgt_col_d = 8'(cur_col_q - CW'(1));
              if (cur_row_q < ROWS_L) begin
                do_wr_d = 1'b1;
                state_d = S_ADDR;
              end
            end else if (cur_row_q != '0) begin
              cur_row_d = cur_row_q - RW'(1);
              cur_col_d = COLS_L - CW'(1);
              tgt_row_d = 8'(cur_row_q - RW'(1));
              tgt_col_d = 8'(COLS_L - CW'(1));
              do_wr_d   = 1'b1;
              state_d   = S_ADDR;
            end
          end
          OP_CLEAR: begin
            cur_row_d   = '0;
            cur_col_d   = '0;
            fill_attr_d = req_q.attribute;
            state_d     = S_CLEAR;
          end
          OP_SET_CUR: begin
            if (in_range) begin
              cur_row_d = RW'(req_q.row);
              cur_col_d = CW'(req_q.column);
              posv_d    = 1'b1;
              state_d   = S_ADDR;
            end
          end
          OP_WRITE_AT: begin
            if (in_range) begin
              do_wr_d = 1'b1;
              state_d = S_ADDR;
            end
          end
          OP_READ_CELL: begin
            if (in_range) begin
              do_rd_d = 1'b1;
              state_d = S_ADDR;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_q == LAST_CELL) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      S_SCR_COPY: begin
        // read one row ahead, write it back in the following cycle
        ram_raddr = cnt_q + COLS_A;
        pend_d    = 1'b1;
        dst_d     = cnt_q;
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = dst_q;
          ram_wdata = ram_rdata;
        end
        if (cnt_q == COPY_LAST) begin
          cnt_d   = FILL_START;
          state_d = S_SCR_FILL;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      S_SCR_FILL: begin
        ram_we = 1'b1;
        if (pend_q) begin
          // drain the last copied cell first
          ram_waddr = dst_q;
          ram_wdata = ram_rdata;
        end else if (cnt_q == LAST_CELL) begin
          state_d = S_ADDR;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      S_ADDR: begin
        state_d = S_ACT;
      end

      S_ACT: begin
        ram_we    = do_wr_q;
        ram_waddr = unit_addr;
        ram_wdata = wdata_q;
        if (posv_q) begin
          pos_d = 16'(unit_addr);
        end
        state_d = do_rd_q ? S_RDWAIT : S_DONE;
      end

      S_RDWAIT: begin
        rd_cell_d = ram_rdata;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      fill_attr_q <= RESET_ATTR;
      def_attr_q  <= RESET_ATTR;
      do_wr_q     <= 1'b0;
      do_rd_q     <= 1'b0;
      posv_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      fill_attr_q <= fill_attr_d;
      do_wr_q     <= do_wr_d;
      do_rd_q     <= do_rd_d;
      posv_q      <= posv_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        def_attr_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    dst_q     <= dst_d;
    tgt_row_q <= tgt_row_d;
    tgt_col_q <= tgt_col_d;
    wdata_q   <= wdata_d;
    pos_q     <= pos_d;
    rd_cell_q <= rd_cell_d;
    if (req_fire) begin
      req_q <= req_i.data;
    end
    if (rsp_load) begin
      rsp_q.cell_char       <= rd_cell_q[7:0];
      rsp_q.cell_attribute  <= rd_cell_q[15:8];
      rsp_q.cursor_row_now  <= 8'(cur_row_q);
      rsp_q.cursor_col_now  <= 8'(cur_col_q);
      rsp_q.cursor_position <= pos_q;
      rsp_q.position_valid  <= posv_q;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Cursor never runs past its saturation points.
  a_cursor_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_row_q <= ROWS_L) && (cur_col_q <= COLS_L))
    else $error("cursor out of bounds");

  // The store is never written while waiting for a request.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("store write in idle");

  // A pending copy write exists only inside a scroll.
  a_pend_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ((state_q == S_SCR_COPY) || (state_q == S_SCR_FILL)))
    else $error("stray copy write");

  // A reported position always lies on the screen.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.position_valid) |-> (rsp_q.cursor_position < 16'(CELLS)))
    else $error("cursor position off screen");

  // A response is loaded only when the previous one is gone or leaving.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |=> ($stable(rsp_q) && rsp_valid_q))
    else $error("response overwritten");

endmodule

[tb/ctw_console_checker.sv]
module ctw_console_checker
  import ctw_pkg::*;
#(
  parameter int COLUMNS = DefColumns,
  parameter int ROWS    = DefRows
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  logic       req_ready_i,
  input  ctw_req_t   req_data_i,
  input  logic       rsp_valid_i,
  input  logic       rsp_ready_i,
  input  ctw_rsp_t   rsp_data_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output int         mismatch_count_o,
  output int         outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cells = COLUMNS * ROWS;

  // {attribute, char} per cell, row major
  logic [15:0] screen_cells [Cells];
  int          cur_row;
  int          cur_col;
  logic [7:0]  blank_attr;
  ctw_rsp_t    console_rsp_q [$];

  task automatic put_cell(int r, int c, logic [7:0] ch, logic [7:0] at);
    if (r < ROWS && c < COLUMNS) screen_cells[r * COLUMNS + c] = {at, ch};
  endtask

  task automatic fill_screen(logic [7:0] at);
    for (int i = 0; i < Cells; i++) screen_cells[i] = {at, BLANK_CHAR};
  endtask

  task automatic shift_screen_up();
    for (int i = 0; i + COLUMNS < Cells; i++) screen_cells[i] = screen_cells[i + COLUMNS];
    for (int c = 0; c < COLUMNS; c++) put_cell(ROWS - 1, c, BLANK_CHAR, blank_attr);
    cur_row = ROWS - 1;
  endtask

  task automatic console_step(input ctw_req_t r, output ctw_rsp_t e);
    int c;
    int rw;
    c  = int'(r.column);
    rw = int'(r.row);
    e  = '0;
    case (r.opcode)
      OP_PUT_CHAR: begin
        // row saturates at ROWS; the next printable char scrolls
        if (r.char_code == NEWLINE_CHAR || cur_col >= COLUMNS) begin
          if (cur_row < ROWS) cur_row++;
          cur_col = 0;
        end
        if (r.char_code != NEWLINE_CHAR) begin
          if (cur_row >= ROWS) shift_screen_up();
          put_cell(cur_row, cur_col, r.char_code, r.attribute);
          cur_col++;
        end
      end
      OP_BACKSPACE: begin
        if (cur_col > 0) begin
          cur_col--;
          put_cell(cur_row, cur_col, BLANK_CHAR, blank_attr);
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = COLUMNS - 1;
          put_cell(cur_row, cur_col, BLANK_CHAR, blank_attr);
        end
      end
      OP_CLEAR: begin
        fill_screen(r.attribute);
        cur_row = 0;
        cur_col = 0;
      end
      OP_SET_CUR: begin
        if (c < COLUMNS && rw < ROWS) begin
          cur_col = c;
          cur_row = rw;
          e.cursor_position = 16'(rw * COLUMNS + c);
          e.position_valid  = 1'b1;
        end
      end
      OP_WRITE_AT: put_cell(rw, c, r.char_code, r.attribute);
      OP_READ_CELL: begin
        if (c < COLUMNS && rw < ROWS) {e.cell_attribute, e.cell_char} = screen_cells[rw * COLUMNS + c];
      end
      default: ;
    endcase
    e.cursor_row_now = 8'(cur_row);
    e.cursor_col_now = 8'(cur_col);
  endtask

  task automatic report_bad(string what, ctw_rsp_t want, ctw_rsp_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $display("%0t %s: expected chr=%02h att=%02h row=%0d col=%0d pos=%0d pv=%0b",
               $time, what, want.cell_char, want.cell_attribute, want.cursor_row_now,
               want.cursor_col_now, want.cursor_position, want.position_valid);
      $display("%0t %s: actual   chr=%02h att=%02h row=%0d col=%0d pos=%0d pv=%0b",
               $time, what, got.cell_char, got.cell_attribute, got.cursor_row_now,
               got.cursor_col_now, got.cursor_position, got.position_valid);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ctw_rsp_t want;
    if (!rst_ni) begin
      fill_screen(RESET_ATTR);
      cur_row          = 0;
      cur_col          = 0;
      blank_attr       = RESET_ATTR;
      mismatch_count_o = 0;
      console_rsp_q.delete();
    end else begin
      if (cfg_we_i) blank_attr = cfg_wdata_i;
      if (rsp_valid_i && rsp_ready_i) begin
        if (console_rsp_q.size() == 0) begin
          report_bad("response with nothing outstanding", '0, rsp_data_i);
        end else begin
          want = console_rsp_q.pop_front();
          if (rsp_data_i.cell_char       !== want.cell_char       ||
              rsp_data_i.cell_attribute  !== want.cell_attribute  ||
              rsp_data_i.cursor_row_now  !== want.cursor_row_now  ||
              rsp_data_i.cursor_col_now  !== want.cursor_col_now  ||
              rsp_data_i.cursor_position !== want.cursor_position ||
              rsp_data_i.position_valid  !== want.position_valid) begin
            report_bad("response mismatch", want, rsp_data_i);
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        console_step(req_data_i, want);
        console_rsp_q.push_back(want);
      end
    end
    outstanding_o = console_rsp_q.size();
  end

endmodule

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ctw_pkg::*;

  localparam int Cols       = DefColumns;
  localparam int Rows       = DefRows;
  localparam int PhaseItems = 163;

  // opcodes the block treats as no-ops
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  logic       calm;          // no idling on either side while set
  int         mismatch_count;
  int         outstanding;
  logic [7:0] attr_plan [4];

  ctw_stream_if #(.data_t(ctw_req_t)) req_if ();
  ctw_stream_if #(.data_t(ctw_rsp_t)) rsp_if ();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  text_console_writer #(
    .COLUMNS(Cols),
    .ROWS   (Rows)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  ctw_console_checker #(
    .COLUMNS(Cols),
    .ROWS   (Rows)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_if.valid),
    .req_ready_i     (req_if.ready),
    .req_data_i      (req_if.data),
    .rsp_valid_i     (rsp_if.valid),
    .rsp_ready_i     (rsp_if.ready),
    .rsp_data_i      (rsp_if.data),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  // roughly 22% idle cycles unless in the calm stretch
  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 22);
  endfunction

  function automatic ctw_req_t make_req(logic [2:0] op, logic [7:0] ch, logic [7:0] at,
                                        logic [7:0] col, logic [7:0] row);
    ctw_req_t r;
    r.opcode    = op;
    r.char_code = ch;
    r.attribute = at;
    r.column    = col;
    r.row       = row;
    return r;
  endfunction

  // mostly on-screen positions, bottom row favored so scrolls come often;
  // the rest keep the full 8-bit random column and row
  function automatic ctw_req_t aim_at_screen(ctw_req_t r);
    if ($urandom_range(99) < 80) begin
      r.column = 8'($urandom_range(Cols - 1));
      r.row    = ($urandom_range(3) == 0) ? 8'(Rows - 1) : 8'($urandom_range(Rows - 1));
    end
    return r;
  endfunction

  // text-heavy mix: runs of put char with newlines, cursor moves, cell
  // writes/reads, rare clears (each one walks the whole store)
  function automatic ctw_req_t random_req();
    ctw_req_t r;
    int       pick;
    r    = make_req(OP_PUT_CHAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 45) begin
      if ($urandom_range(99) < 12) r.char_code = NEWLINE_CHAR;
    end else if (pick < 51) begin
      r.opcode = OP_BACKSPACE;
    end else if (pick < 52) begin
      r.opcode = OP_CLEAR;
    end else if (pick < 64) begin
      r.opcode = OP_SET_CUR;
      r = aim_at_screen(r);
    end else if (pick < 78) begin
      r.opcode = OP_WRITE_AT;
      r = aim_at_screen(r);
    end else if (pick < 96) begin
      r.opcode = OP_READ_CELL;
      r = aim_at_screen(r);
    end else begin
      r.opcode = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
    end
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next call decides whether it drops
  task automatic send_req(input ctw_req_t r);
    while (idle_now()) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // drop valid and wait until every request has been answered
  task automatic settle();
    req_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_blank_attr(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // response side backpressure
  always @(negedge clk_i) rsp_if.ready <= !idle_now();

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = 8'h00;
    calm         = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    attr_plan    = '{8'h00, 8'hFF, 8'($urandom), RESET_ATTR};

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, edges of the screen, wrap and scroll,
    // newline saturation, out-of-range requests, spare opcodes, clear
    send_req(make_req(OP_READ_CELL, 8'h00, 8'h00, 8'h00, 8'h00));
    send_req(make_req(OP_READ_CELL, 8'h00, 8'h00, 8'(Cols - 1), 8'(Rows - 1)));
    send_req(make_req(OP_READ_CELL, 8'h00, 8'h00, 8'(Cols), 8'h00));
    send_req(make_req(OP_READ_CELL, 8'h00, 8'h00, 8'hFF, 8'hFF));
    send_req(make_req(OP_PUT_CHAR, "A", 8'h1F, 8'h00, 8'h00));
    send_req(make_req(OP_BACKSPACE, 8'h00, 8'h00, 8'h00, 8'h00));
    // backspace at home: no change
    send_req(make_req(OP_BACKSPACE, 8'h00, 8'h00, 8'h00, 8'h00));
    send_req(make_req(OP_SET_CUR, 8'h00, 8'h00, 8'(Cols - 1), 8'(Rows - 1)));
    // last cell, then right-edge wrap forces a scroll with the reset attribute
    send_req(make_req(OP_PUT_CHAR, "Z", 8'hFF, 8'h00, 8'h00));
    send_req(make_req(OP_PUT_CHAR, "y", 8'h42, 8'h00, 8'h00));
    send_req(make_req(OP_READ_CELL, 8'h00, 8'h00, 8'(Cols - 1), 8'(Rows - 2)));
    // two newlines: row saturates past the bottom
    send_req(make_req(OP_PUT_CHAR, NEWLINE_CHAR, 8'h00, 8'h00, 8'h00));
    send_req(make_req(OP_PUT_CHAR, NEWLINE_CHAR, 8'h00, 8'h00, 8'h00));
    // backspace from below the screen back onto the last row
    send_req(make_req(OP_BACKSPACE, 8'h00, 8'h00, 8'h00, 8'h00));
    send_req(make_req(OP_PUT_CHAR, NEWLINE_CHAR, 8'h00, 8'h00, 8'h00));
    send_req(make_req(OP_PUT_CHAR, 8'hFF, 8'h00, 8'h00, 8'h00));
    // rejected cursor moves
    send_req(make_req(OP_SET_CUR, 8'h00, 8'h00, 8'(Cols), 8'h00));
    send_req(make_req(OP_SET_CUR, 8'h00, 8'h00, 8'h00, 8'(Rows)));
    send_req(make_req(OP_WRITE_AT, 8'h00, 8'h00, 8'h00, 8'h00));
    send_req(make_req(OP_WRITE_AT, 8'hFF, 8'hFF, 8'(Cols - 1), 8'(Rows - 1)));
    // dropped writes
    send_req(make_req(OP_WRITE_AT, 8'h55, 8'h55, 8'(Cols), 8'h00));
    send_req(make_req(OP_WRITE_AT, 8'hAA, 8'hAA, 8'h00, 8'hFF));
    send_req(make_req(OP_READ_CELL, 8'h00, 8'h00, 8'h00, 8'h00));
    send_req(make_req(OP_SPARE_6, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_req(make_req(OP_SPARE_7, 8'h00, 8'h00, 8'h00, 8'h00));
    send_req(make_req(OP_CLEAR, 8'h00, 8'hA5, 8'h00, 8'h00));
    send_req(make_req(OP_READ_CELL, 8'h00, 8'h00, 8'(Cols - 1), 8'(Rows - 1)));

    // random phases, each under its own default attribute; third one calm
    for (int p = 0; p < 4; p++) begin
      settle();
      write_blank_attr(attr_plan[p]);
      calm = (p == 2);
      repeat (PhaseItems) send_req(random_req());
    end
    calm = 1'b0;

    settle();
    repeat (16) @(negedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #60_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
